[rtl/core/sfcp_pkg.sv]
// ----------------------------------------------------------------------------
// sfcp_pkg
// Shared types and constants for the sync word frame parser with its
// two-sum byte checksum.
// ----------------------------------------------------------------------------
package sfcp_pkg;

    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 10;
    localparam int STAGE_W  = 3;
    localparam int SYNC_W   = 32;
    localparam int LENGTH_W = 11;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_FRAME_BYTES = 1024;
    localparam int LEN_CAP = (MAX_FRAME_BYTES < 1024) ? MAX_FRAME_BYTES : 1024;
    localparam int LEN_HIGH_INT = (LEN_CAP < 7) ? 7 : LEN_CAP;

    localparam logic [LENGTH_W-1:0] LEN_LOW  = LENGTH_W'(7);
    localparam logic [LENGTH_W-1:0] LEN_HIGH = LENGTH_W'(LEN_HIGH_INT);

    localparam logic [SYNC_W-1:0]   SYNC_WORD_RESET    = 32'h1234_5678;
    localparam logic [LENGTH_W-1:0] FRAME_LENGTH_RESET = LENGTH_W'(64);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 1'b1;

    // Hunt stages 0..3 count matched sync bytes; BODY_STAGE is inside a frame.
    localparam logic [STAGE_W-1:0] HUNT_START = 3'd0;
    localparam logic [STAGE_W-1:0] BODY_STAGE = 3'd4;

    typedef struct packed {
        logic [SYNC_W-1:0]   sync_word;
        logic [LENGTH_W-1:0] frame_len;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               in_frame;
        logic               frame_end;
        logic               frame_good;
        logic               header_miss;
    } result_t;

endpackage

[rtl/core/sfcp_if.sv]
// ----------------------------------------------------------------------------
// sfcp_if
// Channel interfaces: received bytes, parse results and configuration writes.
// ----------------------------------------------------------------------------
interface sfcp_rx_if
    import sfcp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcp_res_if
    import sfcp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               in_frame;
    logic               frame_end;
    logic               frame_good;
    logic               header_miss;

    modport source (output valid, output data_byte, output byte_index, output in_frame,
                    output frame_end, output frame_good, output header_miss, input ready);
    modport sink   (input valid, input data_byte, input byte_index, input in_frame,
                    input frame_end, input frame_good, input header_miss, output ready);
endinterface

interface sfcp_cfg_if
    import sfcp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [SYNC_W-1:0]    data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

[rtl/core/sfcp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sfcp_cfg_regs
// Configuration registers. The frame length is clamped to its legal range
// when written, so the parser sees only usable lengths.
// ----------------------------------------------------------------------------
module sfcp_cfg_regs
    import sfcp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [SYNC_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    logic [SYNC_W-1:0]   sync_word_reg;
    logic [LENGTH_W-1:0] frame_len_reg;
    logic [LENGTH_W-1:0] len_raw;
    logic [LENGTH_W-1:0] len_clamped;

    assign len_raw = wr_data[LENGTH_W-1:0];

    always_comb
    begin
        priority if (len_raw < LEN_LOW)
        begin
            len_clamped = LEN_LOW;
        end
        else if (len_raw > LEN_HIGH)
        begin
            len_clamped = LEN_HIGH;
        end
        else
        begin
            len_clamped = len_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= SYNC_WORD_RESET;
            frame_len_reg <= FRAME_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_SYNC_WORD:    sync_word_reg <= wr_data;
                CFG_FRAME_LENGTH: frame_len_reg <= len_clamped;
                default:          sync_word_reg <= sync_word_reg;
            endcase
        end
    end

    assign cfg.sync_word = sync_word_reg;
    assign cfg.frame_len = frame_len_reg;

endmodule

[rtl/core/sfcp_in_stage.sv]
// ----------------------------------------------------------------------------
// sfcp_in_stage
// Input register for received bytes. It refills in the same cycle that the
// held byte moves on.
// ----------------------------------------------------------------------------
module sfcp_in_stage
    import sfcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              in_ready,
    input  logic              advance,
    output logic              held_valid,
    output logic [BYTE_W-1:0] held_byte
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    assign in_ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

[rtl/core/sfcp_core.sv]
// ----------------------------------------------------------------------------
// sfcp_core
// Sync word hunt, frame counter and the two running byte sums. One byte is
// processed per cycle when step is high.
// ----------------------------------------------------------------------------
module sfcp_core
    import sfcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] data_in,
    input  cfg_t              cfg,
    output result_t           result
);

    logic [STAGE_W-1:0] stage_reg,    stage_next;
    logic [INDEX_W-1:0] count_reg,    count_next;
    logic [BYTE_W-1:0]  sum_a_reg,    sum_a_next;
    logic [BYTE_W-1:0]  sum_b_reg,    sum_b_next;
    logic               check_ok_reg, check_ok_next;

    logic [BYTE_W-1:0]   want_byte;
    logic [BYTE_W-1:0]   sum_a_add;
    logic [BYTE_W-1:0]   sum_b_add;
    logic [LENGTH_W-1:0] pos_plus1;
    logic [LENGTH_W-1:0] pos_plus2;
    logic                last_byte;
    logic                check_byte;

    always_comb
    begin
        unique case (stage_reg[1:0])
            2'd0:    want_byte = cfg.sync_word[31:24];
            2'd1:    want_byte = cfg.sync_word[23:16];
            2'd2:    want_byte = cfg.sync_word[15:8];
            default: want_byte = cfg.sync_word[7:0];
        endcase
    end

    assign sum_a_add  = sum_a_reg + data_in;
    assign sum_b_add  = sum_b_reg + sum_a_add;
    assign pos_plus1  = {1'b0, count_reg} + LENGTH_W'(1);
    assign pos_plus2  = {1'b0, count_reg} + LENGTH_W'(2);
    assign last_byte  = pos_plus1 >= cfg.frame_len;
    assign check_byte = pos_plus2 == cfg.frame_len;

    always_comb
    begin
        stage_next    = stage_reg;
        count_next    = count_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        check_ok_next = check_ok_reg;

        result.data_byte   = data_in;
        result.byte_index  = count_reg;
        result.in_frame    = 1'b0;
        result.frame_end   = 1'b0;
        result.frame_good  = 1'b0;
        result.header_miss = 1'b0;

        if (stage_reg != BODY_STAGE)
        begin
            if (data_in == want_byte)
            begin
                result.in_frame = 1'b1;
                sum_a_next      = sum_a_add;
                sum_b_next      = sum_b_add;
                stage_next      = stage_reg + STAGE_W'(1);
                count_next      = count_reg + INDEX_W'(1);
            end
            else
            begin
                // A miss on the first byte is silent; later ones flag a broken header.
                result.header_miss = (stage_reg != HUNT_START);
                stage_next    = HUNT_START;
                count_next    = '0;
                sum_a_next    = '0;
                sum_b_next    = '0;
                check_ok_next = 1'b0;
            end
        end
        else
        begin
            result.in_frame = 1'b1;
            if (last_byte)
            begin
                result.frame_end  = 1'b1;
                result.frame_good = check_ok_reg && (data_in == sum_b_reg);
                stage_next    = HUNT_START;
                count_next    = '0;
                sum_a_next    = '0;
                sum_b_next    = '0;
                check_ok_next = 1'b0;
            end
            else
            begin
                if (check_byte)
                begin
                    check_ok_next = (data_in == sum_a_reg);
                end
                else
                begin
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                end
                count_next = count_reg + INDEX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg    <= HUNT_START;
            count_reg    <= '0;
            sum_a_reg    <= '0;
            sum_b_reg    <= '0;
            check_ok_reg <= 1'b0;
        end
        else if (step)
        begin
            stage_reg    <= stage_next;
            count_reg    <= count_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            check_ok_reg <= check_ok_next;
        end
    end

endmodule

[rtl/core/sfcp_out_stage.sv]
// ----------------------------------------------------------------------------
// sfcp_out_stage
// Result register. It takes a new result whenever it is empty or its
// current result is being taken downstream.
// ----------------------------------------------------------------------------
module sfcp_out_stage
    import sfcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    slot_free,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_result
);

    logic    valid_reg;
    result_t result_reg;

    assign slot_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && slot_free)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

[rtl/core/sync_frame_checksum_parser.sv]
// ----------------------------------------------------------------------------
// sync_frame_checksum_parser
// Hunts for a four-byte sync word, counts the frame to its configured
// length and checks the two running byte sums carried in its last bytes.
// ----------------------------------------------------------------------------
//  Channel   Direction   Moves
//  rx        in          one received byte per request
//  res       out         the byte echoed with index, in-frame and end/good/miss flags
//  cfg       in          register write: 0 sync word, 1 frame length
//
//  One byte per cycle sustained while res is not stalled; a taken byte waits
//  in the input register before it is parsed into the result register,
//  where its result is presented.
//  The hunt state and running sums update in the cycle a byte moves to the
//  result register, so consecutive bytes follow without a gap.
//  A stall on res holds the result register and backs up into rx.
//  Reset returns the hunt to its start and loads the default sync word and
//  a frame length of 64; cfg is always ready.
// ----------------------------------------------------------------------------
module sync_frame_checksum_parser
    import sfcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sfcp_rx_if.sink    rx,
    sfcp_res_if.source res,
    sfcp_cfg_if.sink   cfg
);

    cfg_t              cfg_val;
    result_t           core_result;
    result_t           out_result;
    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              slot_free;
    logic              advance;

    assign cfg.ready = 1'b1;
    assign advance   = held_valid && slot_free;

    sfcp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.reg_index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    sfcp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_byte    (rx.rx_byte),
        .in_ready   (rx.ready),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sfcp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .data_in (held_byte),
        .cfg     (cfg_val),
        .result  (core_result)
    );

    sfcp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (core_result),
        .slot_free  (slot_free),
        .out_ready  (res.ready),
        .out_valid  (res.valid),
        .out_result (out_result)
    );

    assign res.data_byte   = out_result.data_byte;
    assign res.byte_index  = out_result.byte_index;
    assign res.in_frame    = out_result.in_frame;
    assign res.frame_end   = out_result.frame_end;
    assign res.frame_good  = out_result.frame_good;
    assign res.header_miss = out_result.header_miss;

endmodule

[dv/sfcp_result_checker.sv]
// ----------------------------------------------------------------------------
// sfcp_result_checker
// Watches the byte, result and register-write channels of the sync frame
// parser. It keeps its own model of the hunt, the frame count and the two
// running sums, and compares every result with the oldest pending one.
// ----------------------------------------------------------------------------
module sfcp_result_checker
    import sfcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sfcp_rx_if   rx,
    sfcp_res_if  res,
    sfcp_cfg_if  cfg,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [SYNC_W-1:0]   sync_word_q;
    logic [LENGTH_W-1:0] frame_len_q;
    logic [STAGE_W-1:0]  stage_q;
    logic [INDEX_W-1:0]  count_q;
    logic [BYTE_W-1:0]   sum_a_q;
    logic [BYTE_W-1:0]   sum_b_q;
    logic                first_ok_q;
    result_t             pending_results[$];

    function automatic void restart_hunt();
        stage_q    = HUNT_START;
        count_q    = '0;
        sum_a_q    = '0;
        sum_b_q    = '0;
        first_ok_q = 1'b0;
    endfunction

    function automatic void add_to_sums(input logic [BYTE_W-1:0] b);
        sum_a_q = sum_a_q + b;
        sum_b_q = sum_b_q + sum_a_q;
    endfunction

    function automatic int frame_len_eff();
        if (frame_len_q < LEN_LOW)
            return int'(LEN_LOW);
        if (frame_len_q > LEN_HIGH)
            return int'(LEN_HIGH);
        return int'(frame_len_q);
    endfunction

    // Works out the result of one taken byte and advances the parse state.
    function automatic result_t parse_byte(input logic [BYTE_W-1:0] b);
        result_t           r;
        int                len;
        int                idx;
        logic [BYTE_W-1:0] want;
        len          = frame_len_eff();
        idx          = int'(count_q);
        r            = '0;
        r.data_byte  = b;
        r.byte_index = count_q;
        if (stage_q < BODY_STAGE)
        begin
            want = sync_word_q[8 * (3 - int'(stage_q)) +: 8];
            if (b == want)
            begin
                r.in_frame = 1'b1;
                add_to_sums(b);
                stage_q = stage_q + STAGE_W'(1);
                count_q = count_q + INDEX_W'(1);
            end
            else
            begin
                // A broken header byte is consumed; the hunt starts over after it.
                r.header_miss = (stage_q != HUNT_START);
                restart_hunt();
            end
        end
        else
        begin
            r.in_frame = 1'b1;
            if (idx + 1 >= len)
            begin
                r.frame_end  = 1'b1;
                r.frame_good = first_ok_q && (b == sum_b_q);
                restart_hunt();
            end
            else
            begin
                if (idx + 2 == len)
                    first_ok_q = (b == sum_a_q);
                else
                    add_to_sums(b);
                count_q = count_q + INDEX_W'(1);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want, input result_t exp);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h (byte 0x%0h at index %0d)",
                                      name, got, want, exp.data_byte, exp.byte_index));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp;
        if (!rst_n)
        begin
            sync_word_q = SYNC_WORD_RESET;
            frame_len_q = FRAME_LENGTH_RESET;
            restart_hunt();
            pending_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.reg_index == CFG_SYNC_WORD)
                    sync_word_q = cfg.data;
                else if (cfg.reg_index == CFG_FRAME_LENGTH)
                    frame_len_q = cfg.data[LENGTH_W-1:0];
            end
            if (res.valid && res.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result byte 0x%0h index %0d with none pending",
                                              res.data_byte, res.byte_index));
                end
                else
                begin
                    exp = pending_results.pop_front();
                    check_field("data_byte", 16'(res.data_byte), 16'(exp.data_byte), exp);
                    check_field("byte_index", 16'(res.byte_index), 16'(exp.byte_index), exp);
                    check_field("in_frame", 16'(res.in_frame), 16'(exp.in_frame), exp);
                    check_field("frame_end", 16'(res.frame_end), 16'(exp.frame_end), exp);
                    check_field("frame_good", 16'(res.frame_good), 16'(exp.frame_good), exp);
                    check_field("header_miss", 16'(res.header_miss), 16'(exp.header_miss),
                                exp);
                end
            end
            if (rx.valid && rx.ready)
                pending_results.push_back(parse_byte(rx.rx_byte));
            outstanding = pending_results.size();
        end
    end

endmodule

[dv/tb_sync_frame_checksum_parser.sv]
// ----------------------------------------------------------------------------
// tb_sync_frame_checksum_parser
// Drives received bytes and register writes into the sync frame parser:
// header misses, good and corrupted frames, partial frames cut by a length
// change and random noise, under several patterns of idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_sync_frame_checksum_parser
    import sfcp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 200;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
    typedef enum int {FRAME_OK, FRAME_BAD_A, FRAME_BAD_B} frame_kind_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int                  mismatches;
    int                  outstanding;
    int                  items_sent;
    int                  hold_requests;
    int                  cycle_count;
    idle_mode_e          idle_mode;
    logic [SYNC_W-1:0]   cur_sync;
    logic [LENGTH_W-1:0] cur_len;

    sfcp_rx_if  rx_ch();
    sfcp_res_if res_ch();
    sfcp_cfg_if cfg_ch();

    sync_frame_checksum_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    sfcp_result_checker u_result_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx_ch),
        .res         (res_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit gap_now(input bit sender);
        int pct;
        pct = 0;
        if (idle_mode == IDLE_BOTH)
            pct = 8;
        else if ((sender && idle_mode == IDLE_SEND) || (!sender && idle_mode == IDLE_RECV))
            pct = 53;
        return $urandom_range(99) < pct;
    endfunction

    function automatic int clamp_len(input logic [LENGTH_W-1:0] l);
        if (l < LEN_LOW)
            return int'(LEN_LOW);
        if (l > LEN_HIGH)
            return int'(LEN_HIGH);
        return int'(l);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge clk);
        while (gap_now(1'b1))
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        items_sent++;
    endtask

    task automatic send_bytes(input logic [BYTE_W-1:0] bytes[$]);
        foreach (bytes[i])
            send_byte(bytes[i]);
    endtask

    // Stops offering bytes and waits until every pending result has come out.
    task automatic wait_for_results();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SYNC_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.data      <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_sync(input logic [SYNC_W-1:0] word);
        write_reg(CFG_SYNC_WORD, word);
        cur_sync = word;
    endtask

    task automatic program_len(input logic [LENGTH_W-1:0] len);
        write_reg(CFG_FRAME_LENGTH, SYNC_W'(len));
        cur_len = len;
    endtask

    task automatic send_frame(input frame_kind_e kind);
        logic [BYTE_W-1:0] bytes[$];
        logic [BYTE_W-1:0] sum_a;
        logic [BYTE_W-1:0] sum_b;
        for (int i = 3; i >= 0; i--)
            bytes.push_back(cur_sync[8 * i +: 8]);
        repeat (clamp_len(cur_len) - 6)
            bytes.push_back(8'($urandom));
        sum_a = '0;
        sum_b = '0;
        foreach (bytes[i])
        begin
            sum_a = sum_a + bytes[i];
            sum_b = sum_b + sum_a;
        end
        if (kind == FRAME_BAD_A)
            sum_a = sum_a ^ 8'($urandom_range(1, 255));
        if (kind == FRAME_BAD_B)
            sum_b = sum_b ^ 8'($urandom_range(1, 255));
        bytes.push_back(sum_a);
        bytes.push_back(sum_b);
        send_bytes(bytes);
    endtask

    // A header that breaks after one to three matching bytes.
    task automatic send_broken_header();
        int k;
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
            send_byte(cur_sync[8 * (3 - i) +: 8]);
        send_byte(cur_sync[8 * (3 - k) +: 8] ^ 8'($urandom_range(1, 255)));
    endtask

    // Header plus a few body bytes, leaving the parser inside a frame.
    task automatic send_partial_frame(input int body);
        for (int i = 3; i >= 0; i--)
            send_byte(cur_sync[8 * i +: 8]);
        repeat (body)
            send_byte(8'($urandom));
    endtask

    initial
    begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= !gap_now(1'b0);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int phase_start;
        int pick;
        bit paused;
        rx_ch.valid      <= 1'b0;
        rx_ch.rx_byte    <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.reg_index <= CFG_SYNC_WORD;
        cfg_ch.data      <= '0;
        idle_mode     = IDLE_NONE;
        items_sent    = 0;
        hold_requests = 0;
        cur_sync      = SYNC_WORD_RESET;
        cur_len       = FRAME_LENGTH_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default sync word: a first-byte miss, a miss at the second byte, a
        // repeated first byte that is consumed rather than retested, and a
        // miss at the last header byte.
        send_bytes({8'h00, 8'h12, 8'h00, 8'h12, 8'h12, 8'h34, 8'h12, 8'h34, 8'h56, 8'hFF});
        wait_for_results();
        program_sync(32'hFF00_8001);
        program_len(LENGTH_W'(7));
        send_frame(FRAME_OK);
        send_frame(FRAME_BAD_B);
        // Leave a frame open; the first phase shortens the length under it.
        wait_for_results();
        program_len(LENGTH_W'(20));
        send_partial_frame(2);

        for (int p = 0; p < 8; p++)
        begin
            wait_for_results();
            idle_mode = idle_mode_e'(p % 4);
            if (p == 1)
                program_sync(32'hFFFF_FFFF);
            else if (p == 2)
                program_sync(32'h0000_0000);
            else if (p == 5)
                program_sync({4{8'($urandom)}});
            else
                program_sync($urandom);
            if (p == 0)
                program_len(LENGTH_W'(7));
            else if (p == 3)
                program_len(LENGTH_W'(2047));
            else if (p == 5)
                program_len(LENGTH_W'($urandom_range(0, 6)));
            else if (p == 6)
                program_len(LENGTH_W'($urandom_range(41, 120)));
            else
                program_len(LENGTH_W'($urandom_range(8, 40)));
            if (p == 2)
                hold_requests++;
            if (p == 3)
                send_frame(FRAME_OK);
            else
            begin
                phase_start = items_sent;
                paused      = 1'b0;
                while (items_sent - phase_start < 110)
                begin
                    if (p == 1 && !paused && items_sent - phase_start >= 55)
                    begin
                        wait_for_results();
                        paused = 1'b1;
                    end
                    pick = $urandom_range(99);
                    if (pick < 45)
                        send_frame(FRAME_OK);
                    else if (pick < 55)
                        send_frame(FRAME_BAD_A);
                    else if (pick < 65)
                        send_frame(FRAME_BAD_B);
                    else if (pick < 82)
                        send_broken_header();
                    else
                        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
            end
            if (p % 2 == 1)
                send_partial_frame($urandom_range(0, 4));
        end

        wait_for_results();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
